FILE: src/qtg_pkg.sv
package qtg_pkg;

    localparam int SAMPLE_RATE        = 44100;
    localparam int QUEUE_DEPTH        = 16;
    localparam int SINE_TABLE_ENTRIES = 1024;

    // field widths
    localparam int FREQ_W    = 15;
    localparam int DUR_W     = 16;
    localparam int WAVE_W    = 3;
    localparam int AMP_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int QCOUNT_W  = 5;
    localparam int SAMPLES_W = 22;
    localparam int PHASE_W   = 16;
    localparam int ACC_W     = PHASE_W + 1;
    localparam int TURN_W    = 16;
    localparam int TABLE_W   = 15;
    localparam int WAVEV_W   = 18;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(28000);

    // shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // samples = dur * SAMPLE_RATE / 1000, with 1000 = 8 * 125
    localparam int DUR_SR_W       = DUR_W + PHASE_W;
    localparam int MS_SHIFT       = 3;
    localparam int MS_ODD         = 125;
    localparam int MS_X_W         = DUR_SR_W - MS_SHIFT;
    localparam int MS_RECIP_SHIFT = 35;
    localparam longint unsigned MS_RECIP = (64'd1 << MS_RECIP_SHIFT) / MS_ODD;
    localparam int MS_QE_W        = MS_X_W + 30 - MS_RECIP_SHIFT;

    // turn = phase * 65536 / SAMPLE_RATE
    localparam int Q_SHIFT = 28;
    localparam longint unsigned Q_RECIP = (64'd1 << (Q_SHIFT + TURN_W)) / SAMPLE_RATE;

    localparam logic [ACC_W-1:0] SR_ACC = ACC_W'(SAMPLE_RATE);

    typedef struct packed {
        logic [FREQ_W-1:0]    freq;
        logic [WAVE_W-1:0]    wave;
        logic [SAMPLES_W-1:0] samples;
    } note_t;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NMUL,
        ST_NREC,
        ST_NBACK,
        ST_NFIX,
        ST_FETCH,
        ST_QMUL,
        ST_QFIX,
        ST_IMUL,
        ST_ROM,
        ST_AMUL,
        ST_TDONE,
        ST_WRAP,
        ST_RELOAD,
        ST_OUT
    } qtg_state_t;

    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = WAVE_W'(1);
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = WAVE_W'(2);
    localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = WAVE_W'(3);

    localparam logic REQ_ENQUEUE = 1'b0;

    typedef logic [TABLE_W-1:0] sine_table_t [SINE_TABLE_ENTRIES+1];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    // quarter-wave table by Taylor series in Q30, evaluated at elaboration
    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] r;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            x  = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
            x2 = mul_q30(x, x);
            s  = ONE_Q30 - x2 / 110;
            s  = ONE_Q30 - mul_q30(x2, s) / 72;
            s  = ONE_Q30 - mul_q30(x2, s) / 42;
            s  = ONE_Q30 - mul_q30(x2, s) / 20;
            s  = ONE_Q30 - mul_q30(x2, s) / 6;
            s  = mul_q30(x, s);
            r  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            t[k] = TABLE_W'(r);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

endpackage

FILE: src/queued_tone_generator.sv
// Tone generator fed by a queue of notes.
// Input channel s_axis: tuser 0 enqueues a note (frequency, duration in ms,
// waveform), tuser 1 is a sample tick. Every item gives exactly one result
// item on m_axis: the sample for a tick (0 when the queue is empty), flags
// for a played note and an accepted request, and the queue occupancy.
// The amplitude register is written through amplitude_we/amplitude_wdata.
// All arithmetic runs through one registered 33x33 multiplier under a
// sequencer, so s_axis_tready is high only while the sequencer is idle.
// An enqueue passes the steps NMUL, NREC, NBACK and NFIX before its result;
// a tick on an empty queue goes straight to its result. A played tick passes
// FETCH, QMUL, QFIX, IMUL, ROM, AMUL, TDONE and WRAP, taking WRAP again when
// the advanced phase wraps past the sample rate, and then RELOAD when the head
// note finishes and the next note's length is fetched from the queue.
// The sequencer is ready again in the cycle after its result is loaded.
// The result sits in an output register; a new item is taken while it waits,
// and the sequencer holds its finished result until m_axis_tready frees it.
// Synchronous active-low reset empties the queue, clears the phase and sets
// the amplitude to 28000; the sine table is a constant ROM and needs no fill.
module queued_tone_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          amplitude_we,
    input  logic [qtg_pkg::AMP_W-1:0]     amplitude_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // tone_freq, duration_ms, waveform
    input  logic                          s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // sample, queue_count
    output logic [1:0]                    m_axis_tuser   // note_active, accepted
);
    import qtg_pkg::*;

    qtg_state_t state_reg, state_next;

    logic                   req_reg, req_next;
    logic [FREQ_W-1:0]      freq_reg, freq_next;
    logic [DUR_W-1:0]       dur_reg, dur_next;
    logic [WAVE_W-1:0]      wave_reg, wave_next;
    logic [AMP_W-1:0]       amp_reg, amp_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SAMPLES_W-1:0]   head_left_reg, head_left_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [MS_X_W-1:0]      x_reg, x_next;
    logic [MS_QE_W-1:0]     qe_reg, qe_next;
    logic [TURN_W-1:0]      q_reg, q_next;
    logic [TABLE_W-1:0]     rom_reg;
    logic                   pop_reg, pop_next;
    logic [SAMPLE_W-1:0]    res_sample_reg, res_sample_next;
    logic                   res_active_reg, res_active_next;
    logic                   res_accepted_reg, res_accepted_next;
    logic                   m_valid_reg, m_valid_next;
    logic [23:0]            m_data_reg, m_data_next;
    logic [1:0]             m_user_reg, m_user_next;

    note_t                  fifo_mem [QUEUE_DEPTH];
    note_t                  rd_note_reg;
    note_t                  wr_note;
    logic                   fifo_we;

    mul_req_t               mul_req;
    logic signed [PROD_W-1:0] prod;

    logic                   in_fire;
    logic                   out_free;
    logic [SAMPLES_W-1:0]   new_samples;
    logic [MS_X_W:0]        ms_resid;
    logic [DUR_SR_W-1:0]    q_resid;
    logic [IDX_W-1:0]       idx_raw;
    logic [IDX_W-1:0]       rom_idx;
    logic signed [WAVEV_W-1:0] wave_val;
    logic signed [WAVEV_W-1:0] q_ext;
    logic signed [WAVEV_W-1:0] rom_ext;
    logic [SAMPLES_W-1:0]   head_dec;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    qtg_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // note queue storage
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[wr_ptr_reg] <= wr_note;
        end
        rd_note_reg <= fifo_mem[rd_ptr_reg];
    end

    // sine ROM, registered read, mirrored in odd quadrants
    assign idx_raw = prod[14 +: IDX_W];
    assign rom_idx = q_reg[14] ? IDX_W'(SINE_TABLE_ENTRIES) - idx_raw : idx_raw;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROM) begin
            rom_reg <= SINE_TABLE[rom_idx];
        end
    end

    // wave value in Q15 from the turn
    assign q_ext   = WAVEV_W'(q_reg);
    assign rom_ext = WAVEV_W'(rom_reg);

    always_comb begin
        case (rd_note_reg.wave)
            WAVE_SQUARE: begin
                wave_val = q_reg[15] ? -WAVEV_W'(32768) : WAVEV_W'(32768);
            end
            WAVE_TRIANGLE: begin
                if (q_reg < TURN_W'(16384)) begin
                    wave_val = q_ext <<< 1;
                end else if (q_reg < TURN_W'(49152)) begin
                    wave_val = WAVEV_W'(65536) - (q_ext <<< 1);
                end else begin
                    wave_val = (q_ext <<< 1) - WAVEV_W'(131072);
                end
            end
            WAVE_SAWTOOTH: begin
                wave_val = q_reg[15] ? q_ext - WAVEV_W'(65536) : q_ext;
            end
            default: begin
                wave_val = q_reg[15] ? -rom_ext : rom_ext;
            end
        endcase
    end

    // multiplier operands by step
    always_comb begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_NMUL: begin
                mul_req.a = MUL_W'(dur_reg);
                mul_req.b = MUL_W'(SAMPLE_RATE);
            end
            ST_NREC: begin
                mul_req.a = MUL_W'(prod[MS_SHIFT +: MS_X_W]);
                mul_req.b = MUL_W'(MS_RECIP);
            end
            ST_NBACK: begin
                mul_req.a = MUL_W'(prod[MS_RECIP_SHIFT +: MS_QE_W]);
                mul_req.b = MUL_W'(MS_ODD);
            end
            ST_FETCH: begin
                mul_req.a = MUL_W'(phase_reg);
                mul_req.b = MUL_W'(Q_RECIP);
            end
            ST_QMUL: begin
                mul_req.a = MUL_W'(prod[Q_SHIFT +: TURN_W]);
                mul_req.b = MUL_W'(SAMPLE_RATE);
            end
            ST_IMUL: begin
                mul_req.a = MUL_W'(q_reg[13:0]);
                mul_req.b = MUL_W'(SINE_TABLE_ENTRIES);
            end
            ST_AMUL: begin
                mul_req.a = MUL_W'(wave_val);
                mul_req.b = MUL_W'(amp_reg);
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == REQ_ENQUEUE) begin
                        state_next = ST_NMUL;
                    end else if (count_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_NMUL:   state_next = ST_NREC;
            ST_NREC:   state_next = ST_NBACK;
            ST_NBACK:  state_next = ST_NFIX;
            ST_NFIX:   state_next = ST_OUT;
            ST_FETCH:  state_next = ST_QMUL;
            ST_QMUL:   state_next = ST_QFIX;
            ST_QFIX:   state_next = ST_IMUL;
            ST_IMUL:   state_next = ST_ROM;
            ST_ROM:    state_next = ST_AMUL;
            ST_AMUL:   state_next = ST_TDONE;
            ST_TDONE:  state_next = ST_WRAP;
            ST_WRAP: begin
                if (acc_reg < SR_ACC) begin
                    state_next = pop_reg ? ST_RELOAD : ST_OUT;
                end
            end
            ST_RELOAD: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign ms_resid = (MS_X_W + 1)'(x_reg) - (MS_X_W + 1)'(prod[MS_X_W-1:0]);
    assign q_resid  = {phase_reg, {TURN_W{1'b0}}} - prod[DUR_SR_W-1:0];
    assign new_samples = SAMPLES_W'(qe_reg + ((ms_resid >= (MS_X_W + 1)'(MS_ODD)) ? 1'b1 : 1'b0));
    assign head_dec = (head_left_reg != '0) ? head_left_reg - 1'b1 : head_left_reg;

    // datapath
    always_comb begin
        req_next          = req_reg;
        freq_next         = freq_reg;
        dur_next          = dur_reg;
        wave_next         = wave_reg;
        amp_next          = amplitude_we ? amplitude_wdata : amp_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        count_next        = count_reg;
        head_left_next    = head_left_reg;
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        x_next            = x_reg;
        qe_next           = qe_reg;
        q_next            = q_reg;
        pop_next          = pop_reg;
        res_sample_next   = res_sample_reg;
        res_active_next   = res_active_reg;
        res_accepted_next = res_accepted_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;
        fifo_we           = 1'b0;
        wr_note.freq      = freq_reg;
        wr_note.wave      = wave_reg;
        wr_note.samples   = new_samples;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    req_next          = s_axis_tuser;
                    freq_next         = s_axis_tdata[14:0];
                    dur_next          = s_axis_tdata[30:15];
                    wave_next         = s_axis_tdata[33:31];
                    res_sample_next   = '0;
                    res_active_next   = 1'b0;
                    res_accepted_next = 1'b0;
                    pop_next          = 1'b0;
                end
            end
            ST_NREC: begin
                x_next = prod[MS_SHIFT +: MS_X_W];
            end
            ST_NBACK: begin
                qe_next = prod[MS_RECIP_SHIFT +: MS_QE_W];
            end
            ST_NFIX: begin
                // drop empty notes, refuse when full
                if (new_samples != '0 && count_reg < CNT_W'(QUEUE_DEPTH)) begin
                    fifo_we           = 1'b1;
                    if (count_reg == '0) begin
                        head_left_next = new_samples;
                    end
                    wr_ptr_next       = ptr_inc(wr_ptr_reg);
                    count_next        = count_reg + 1'b1;
                    res_accepted_next = 1'b1;
                end
            end
            ST_QMUL: begin
                qe_next = MS_QE_W'(prod[Q_SHIFT +: TURN_W]);
            end
            ST_QFIX: begin
                q_next = TURN_W'(qe_reg) +
                         ((q_resid >= DUR_SR_W'(SAMPLE_RATE)) ? 1'b1 : 1'b0);
            end
            ST_TDONE: begin
                // floor(v * amplitude / 32768) always fits 16 bits
                res_sample_next = prod[15 +: SAMPLE_W];
                res_active_next = 1'b1;
                acc_next        = ACC_W'(phase_reg) + ACC_W'(rd_note_reg.freq);
                head_left_next  = head_dec;
                if (head_dec == '0) begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    count_next  = count_reg - 1'b1;
                    pop_next    = (count_reg != CNT_W'(1));
                end
            end
            ST_WRAP: begin
                if (acc_reg >= SR_ACC) begin
                    acc_next = acc_reg - SR_ACC;
                end else begin
                    phase_next = acc_reg[PHASE_W-1:0];
                end
            end
            ST_RELOAD: begin
                head_left_next = rd_note_reg.samples;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, QCOUNT_W'(count_reg), res_sample_reg};
                    m_user_next  = {res_accepted_reg, res_active_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            amp_reg       <= AMP_RESET;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            head_left_reg <= '0;
            phase_reg     <= '0;
            pop_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            amp_reg       <= amp_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            head_left_reg <= head_left_next;
            phase_reg     <= phase_next;
            pop_reg       <= pop_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        freq_reg         <= freq_next;
        dur_reg          <= dur_next;
        wave_reg         <= wave_next;
        acc_reg          <= acc_next;
        x_reg            <= x_next;
        qe_reg           <= qe_next;
        q_reg            <= q_next;
        res_sample_reg   <= res_sample_next;
        res_active_reg   <= res_active_next;
        res_accepted_reg <= res_accepted_next;
        m_data_reg       <= m_data_next;
        m_user_reg       <= m_user_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("note count beyond queue depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty queue with pointers apart");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PHASE_W'(SAMPLE_RATE))
        else $error("phase out of range");

    a_head_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg != '0) |-> head_left_reg != '0)
        else $error("queued head note with no samples left");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_user_reg[0] && m_user_reg[1]))
        else $error("result both played and accepted");

    a_tick_req: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> req_reg != REQ_ENQUEUE)
        else $error("tick path entered by an enqueue item");
`endif

endmodule

FILE: src/qtg_mul.sv
module qtg_mul (
    input  logic                          aclk,
    input  qtg_pkg::mul_req_t             req,
    output logic signed [qtg_pkg::PROD_W-1:0] prod
);
    import qtg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // hold the product until the next issue
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: sim/queued_tone_generator_test.sv
module queued_tone_generator_test;
    import qtg_pkg::*;

    localparam logic                REQ_TICK    = ~REQ_ENQUEUE;
    localparam logic [WAVE_W-1:0]   WAVE_SINE   = '0;
    localparam longint unsigned     PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned     UNIT_Q30    = 64'd1 << 30;
    localparam int unsigned         MS_PER_S    = 1000;
    localparam int unsigned         SETTLE      = 24;
    localparam int unsigned         CYCLE_LIMIT = 400000;
    localparam int unsigned         PHASE_ITEMS = 140;

    typedef struct packed {
        logic               req;
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
        logic [WAVE_W-1:0]  wave;
    } tone_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
        logic                       accepted;
        logic [QCOUNT_W-1:0]        count;
    } tone_res_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                amplitude_we    = 1'b0;
    logic [AMP_W-1:0]    amplitude_wdata = '0;
    logic                s_axis_tvalid   = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata    = '0;  // tone_freq, duration_ms, waveform
    logic                s_axis_tuser    = 1'b0;  // req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready   = 1'b0;
    logic [23:0]         m_axis_tdata;  // sample, queue_count
    logic [1:0]          m_axis_tuser;  // note_active, accepted

    queued_tone_generator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .amplitude_we    (amplitude_we),
        .amplitude_wdata (amplitude_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // tone model state
    int                  quarter_wave [SINE_TABLE_ENTRIES+1];
    logic [FREQ_W-1:0]   slot_freq [QUEUE_DEPTH];
    logic [WAVE_W-1:0]   slot_wave [QUEUE_DEPTH];
    int unsigned         slot_len  [QUEUE_DEPTH];
    int unsigned         head_slot;
    int unsigned         tail_slot;
    int unsigned         notes_held;
    int unsigned         head_left;
    int unsigned         phase_acc;
    int unsigned         amp_reg;

    tone_req_t           pending_reqs [$];
    tone_res_t           awaited_results [$];
    int unsigned         plan_len [$];
    int unsigned         reqs_queued;
    int unsigned         results_seen;
    int unsigned         fail_count;
    int unsigned         cycle_count;
    int unsigned         send_hold;
    int unsigned         send_calm;
    int unsigned         recv_hold;
    int unsigned         recv_calm;
    tone_req_t           on_bus;
    tone_res_t           want;
    int unsigned         probe_freq [8] = '{0, 32767, 1, 11025, 22050, 440, 16384, 30000};

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic void fill_quarter_wave();
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned pt;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            ang = PI_HALF_Q30 * 64'(k) / SINE_TABLE_ENTRIES;
            sq  = q30_mul(ang, ang);
            // Horner form of the odd series up to the eleventh power
            acc = UNIT_Q30 - sq / 110;
            acc = UNIT_Q30 - q30_mul(sq, acc) / 72;
            acc = UNIT_Q30 - q30_mul(sq, acc) / 42;
            acc = UNIT_Q30 - q30_mul(sq, acc) / 20;
            acc = UNIT_Q30 - q30_mul(sq, acc) / 6;
            acc = q30_mul(ang, acc);
            pt  = (acc * 32767 + (UNIT_Q30 >> 1)) >> 30;
            if (pt > 32767) begin
                pt = 32767;
            end
            quarter_wave[k] = int'(pt);
        end
    endfunction

    function automatic int wave_point(logic [WAVE_W-1:0] wave, int turn);
        int quad;
        int idx;
        case (wave)
            WAVE_SQUARE: begin
                return (turn < 32768) ? 32768 : -32768;
            end
            WAVE_TRIANGLE: begin
                if (turn < 16384) begin
                    return 2 * turn;
                end
                if (turn < 49152) begin
                    return 65536 - 2 * turn;
                end
                return 2 * turn - 131072;
            end
            WAVE_SAWTOOTH: begin
                return (turn < 32768) ? turn : turn - 65536;
            end
            default: begin
                quad = (turn >> 14) & 3;
                idx  = ((turn & 16383) * SINE_TABLE_ENTRIES) >> 14;
                // mirror odd quadrants, negate the second half-turn
                if (quad & 1) begin
                    idx = SINE_TABLE_ENTRIES - idx;
                end
                return (quad & 2) ? -quarter_wave[idx] : quarter_wave[idx];
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] scale_to_amp(int v);
        longint p;
        longint r;
        p = longint'(v) * longint'(amp_reg);
        if (p >= 0) begin
            r = p / 32768;
        end else begin
            r = -((-p + 32767) / 32768);
        end
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return SAMPLE_W'(r);
    endfunction

    function automatic tone_res_t next_tone_result(tone_req_t rq);
        tone_res_t        res;
        longint unsigned  span;
        int unsigned      len;
        int               turn;
        res = '0;
        if (rq.req == REQ_ENQUEUE) begin
            span = (64'(rq.dur) * SAMPLE_RATE) / MS_PER_S;
            len  = span[SAMPLES_W-1:0];
            if (len != 0 && notes_held < QUEUE_DEPTH) begin
                slot_freq[tail_slot] = rq.freq;
                slot_wave[tail_slot] = rq.wave;
                slot_len[tail_slot]  = len;
                if (notes_held == 0) begin
                    head_left = len;
                end
                tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
                notes_held++;
                res.accepted = 1'b1;
            end
        end else if (notes_held != 0) begin
            turn = int'((64'(phase_acc) * 65536) / SAMPLE_RATE);
            res.sample = scale_to_amp(wave_point(slot_wave[head_slot], turn));
            res.active = 1'b1;
            phase_acc = (phase_acc + slot_freq[head_slot]) % SAMPLE_RATE;
            if (head_left != 0) begin
                head_left--;
            end
            if (head_left == 0) begin
                head_slot = (head_slot + 1) % QUEUE_DEPTH;
                notes_held--;
                if (notes_held != 0) begin
                    head_left = slot_len[head_slot];
                end
            end
        end
        res.count = QCOUNT_W'(notes_held);
        return res;
    endfunction

    // mostly none or short, a few long, now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string field, input logic signed [31:0] got,
                                 input logic signed [31:0] exp_val);
        $display("mismatch on result %0d: %s is %0d, should be %0d",
                 results_seen, field, got, exp_val);
        fail_count++;
    endtask

    // stimulus planning keeps a rough note of queued lengths to steer the mix
    function automatic void plan_enqueue(logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur,
                                         logic [WAVE_W-1:0] wave);
        tone_req_t   rq;
        int unsigned len;
        rq.req  = REQ_ENQUEUE;
        rq.freq = freq;
        rq.dur  = dur;
        rq.wave = wave;
        pending_reqs.push_back(rq);
        reqs_queued++;
        len = (dur * SAMPLE_RATE) / MS_PER_S;
        if (len != 0 && plan_len.size() < QUEUE_DEPTH) begin
            plan_len.push_back(len);
        end
    endfunction

    function automatic void plan_tick();
        tone_req_t rq;
        rq      = '0;
        rq.req  = REQ_TICK;
        rq.freq = FREQ_W'($urandom_range(0, 32767));
        rq.dur  = DUR_W'($urandom_range(0, 65535));
        rq.wave = WAVE_W'($urandom_range(0, 7));
        pending_reqs.push_back(rq);
        reqs_queued++;
        if (plan_len.size() != 0) begin
            plan_len[0]--;
            if (plan_len[0] == 0) begin
                void'(plan_len.pop_front());
            end
        end
    endfunction

    function automatic logic [DUR_W-1:0] short_dur();
        return ($urandom_range(0, 9) < 7) ? DUR_W'(1) : DUR_W'(2);
    endfunction

    function automatic void plan_short_note();
        plan_enqueue(FREQ_W'($urandom_range(0, 32767)), short_dur(),
                     WAVE_W'($urandom_range(0, 7)));
    endfunction

    function automatic int unsigned queued_samples();
        int unsigned total;
        total = 0;
        foreach (plan_len[i]) begin
            total += plan_len[i];
        end
        return total;
    endfunction

    // mostly ticks; a stray note, a dropped note, or a full-width refused request
    function automatic void plan_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            plan_short_note();
        end else if (r < 7) begin
            if (plan_len.size() == QUEUE_DEPTH) begin
                plan_enqueue(FREQ_W'($urandom_range(0, 32767)),
                             DUR_W'($urandom_range(0, 65535)),
                             WAVE_W'($urandom_range(0, 7)));
            end else begin
                plan_enqueue(FREQ_W'($urandom_range(0, 32767)), '0,
                             WAVE_W'($urandom_range(0, 7)));
            end
        end else begin
            plan_tick();
        end
    endfunction

    function automatic void plan_random_phase(int unsigned budget);
        int unsigned first;
        int unsigned steps;
        int unsigned used;
        first = reqs_queued;
        while (reqs_queued - first < budget) begin
            case ($urandom_range(0, 9))
                7, 8: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 1)) begin
                            plan_tick();
                        end else begin
                            plan_enqueue(FREQ_W'($urandom_range(0, 32767)), '0,
                                         WAVE_W'($urandom_range(0, 7)));
                        end
                    end
                end
                9: begin
                    repeat ($urandom_range(2, 5)) plan_short_note();
                end
                default: begin
                    repeat ($urandom_range(1, 2)) begin
                        if (plan_len.size() < QUEUE_DEPTH) begin
                            plan_short_note();
                        end
                    end
                    // play out the queue and run dry, or stop partway
                    if ($urandom_range(0, 1)) begin
                        steps = queued_samples() + $urandom_range(0, 4);
                    end else begin
                        steps = $urandom_range(20, 120);
                    end
                    // keep within the phase budget
                    used = reqs_queued - first;
                    if (used >= budget) begin
                        steps = 0;
                    end else if (steps > budget - used) begin
                        steps = budget - used;
                    end
                    repeat (steps) plan_step();
                end
            endcase
        end
    endfunction

    task automatic wait_idle();
        do @(posedge aclk); while (results_seen < reqs_queued);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_amplitude(int unsigned level);
        amplitude_wdata <= AMP_W'(level);
        amplitude_we    <= 1'b1;
        amp_reg = level;
        @(posedge aclk);
        amplitude_we    <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(next_tone_result(on_bus));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    on_bus = pending_reqs.pop_front();
                    s_axis_tdata  <= {{(40 - FREQ_W - DUR_W - WAVE_W){1'b0}},
                                      on_bus.wave, on_bus.dur, on_bus.freq};
                    s_axis_tuser  <= on_bus.req;
                    s_axis_tvalid <= 1'b1;
                    send_hold = pick_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("item with nothing awaited, sample",
                                  $signed(m_axis_tdata[SAMPLE_W-1:0]), 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample) begin
                        flag_mismatch("sample", $signed(m_axis_tdata[SAMPLE_W-1:0]),
                                      want.sample);
                    end
                    if (m_axis_tdata[SAMPLE_W +: QCOUNT_W] !== want.count) begin
                        flag_mismatch("queue_count", m_axis_tdata[SAMPLE_W +: QCOUNT_W],
                                      want.count);
                    end
                    if (m_axis_tuser[0] !== want.active) begin
                        flag_mismatch("note_active", m_axis_tuser[0], want.active);
                    end
                    if (m_axis_tuser[1] !== want.accepted) begin
                        flag_mismatch("accepted", m_axis_tuser[1], want.accepted);
                    end
                end
                results_seen++;
                recv_hold = pick_gap(recv_calm);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("queued_tone_generator_test NOT OK");
            $finish;
        end
    end

    initial begin
        fill_quarter_wave();
        head_slot  = 0;
        tail_slot  = 0;
        notes_held = 0;
        head_left  = 0;
        phase_acc  = 0;
        amp_reg    = 28000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        plan_tick();                               // empty queue: silence, phase holds
        plan_enqueue(15'd440, '0, WAVE_SINE);      // zero length: drop
        for (int w = 0; w < 8; w++) begin
            plan_enqueue(FREQ_W'(probe_freq[w]), DUR_W'(1), WAVE_W'(w));
        end
        repeat (8) plan_enqueue(FREQ_W'($urandom_range(0, 32767)), DUR_W'(1),
                                WAVE_W'($urandom_range(0, 7)));
        plan_enqueue('1, '1, '1);                  // queue full: refuse
        repeat (3) plan_tick();
        wait_idle();

        plan_random_phase(PHASE_ITEMS);
        wait_idle();
        set_amplitude(32767);
        plan_random_phase(PHASE_ITEMS);
        wait_idle();
        set_amplitude(0);
        plan_random_phase(PHASE_ITEMS);
        wait_idle();
        set_amplitude(1);
        plan_random_phase(PHASE_ITEMS);
        wait_idle();
        set_amplitude($urandom_range(2, 32766));
        plan_random_phase(PHASE_ITEMS);
        wait_idle();

        if (awaited_results.size() != 0) begin
            flag_mismatch("results never delivered", awaited_results.size(), 0);
        end
        if (fail_count == 0) begin
            $display("queued_tone_generator_test OK");
        end else begin
            $display("queued_tone_generator_test NOT OK");
        end
        $finish;
    end

endmodule
